// ===== rtl/fodf_pkg.sv =====
// shared types and constants for the first-occurrence dedup filter
package fodf_pkg;

  localparam int WORD_W = 32;
  localparam int UCNT_W = 9;

  typedef struct packed {
    logic [WORD_W-1:0] value_out;
    logic              keep;
    logic [UCNT_W-1:0] unique_count;
    logic              overflow;
    logic              last_out;
  } res_beat_t;

endpackage

// ===== rtl/first_occurrence_dedup_filter_top.sv =====
// top level of the first-occurrence dedup filter
//
// channel | dir | handshake              | content
// in_     | in  | in_tvalid / in_tready  | tdata value, tlast last
// out_    | out | out_tvalid / out_tready| tdata value_out, unique_count; tuser keep, overflow
//
// a beat is compared against up to n words, n the unique words stored in the current set (at most
// STORE_DEPTH): one compare per cycle against the memory's single read port
// reset clears the count and the handshake state; the memory needs no clearing
// a finished result waits in the output register while the next beat is accepted
// a stalled output holds the next result in its decide step until the register frees
module first_occurrence_dedup_filter_top #(
  parameter int STORE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] value_out, [40:32] unique_count, [47:41] zero
  output logic [1:0]  out_tuser,  // [0] keep, [1] overflow
  output logic        out_tlast
);
  import fodf_pkg::*;

  localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);

  res_beat_t         res;
  logic              mem_wr_en;
  logic [IW-1:0]     mem_wr_addr;
  logic [WORD_W-1:0] mem_wr_data;
  logic [IW-1:0]     mem_rd_addr;
  logic [WORD_W-1:0] mem_rd_data;

  fodf_store #(
    .DEPTH (STORE_DEPTH),
    .IW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  fodf_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .IW          (IW),
    .CW          (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_value    (in_tdata),
    .in_last     (in_tlast),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  assign out_tdata = {7'd0, res.unique_count, res.value_out};
  assign out_tuser = {res.overflow, res.keep};
  assign out_tlast = res.last_out;

endmodule

// ===== rtl/fodf_store.sv =====
// unique-word memory: one write port, one registered read port
module fodf_store #(
  parameter int DEPTH = 256,
  parameter int IW    = 8
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [IW-1:0]               wr_addr,
  input  logic [fodf_pkg::WORD_W-1:0] wr_data,
  input  logic [IW-1:0]               rd_addr,
  output logic [fodf_pkg::WORD_W-1:0] rd_data
);
  import fodf_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/fodf_ctrl.sv =====
// scan sequencer with shared comparator, unique count and result register
module fodf_ctrl #(
  parameter int STORE_DEPTH = 256,
  parameter int IW          = 8,
  parameter int CW          = 9
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fodf_pkg::WORD_W-1:0] in_value,
  input  logic                        in_last,
  output logic                        res_valid,
  input  logic                        res_ready,
  output fodf_pkg::res_beat_t         res,
  output logic                        mem_wr_en,
  output logic [IW-1:0]               mem_wr_addr,
  output logic [fodf_pkg::WORD_W-1:0] mem_wr_data,
  output logic [IW-1:0]               mem_rd_addr,
  input  logic [fodf_pkg::WORD_W-1:0] mem_rd_data
);
  import fodf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  localparam logic [CW-1:0] FULL_CNT = CW'(STORE_DEPTH);

  state_t            state_r, state_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic              last_r, last_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic              found_r, found_nxt;
  logic              res_valid_r, res_valid_nxt;
  res_beat_t         res_r, res_nxt;

  logic              issue;
  logic              hit;
  logic              full;
  logic              keep;
  logic              ovf;
  logic              res_free;
  logic [CW-1:0]     new_count;
  logic [CW+UCNT_W-1:0] count_ext;

  assign issue     = (idx_r < count_r);
  assign hit       = pend_r && (mem_rd_data == word_r);
  assign full      = (count_r == FULL_CNT);
  assign keep      = !found_r && !full;
  assign ovf       = !found_r && full;
  assign new_count = count_r + CW'(keep);
  assign count_ext = {{UCNT_W{1'b0}}, new_count};
  assign res_free  = !res_valid_r || res_ready;

  assign in_ready    = (state_r == ST_IDLE);
  assign res_valid   = res_valid_r;
  assign res         = res_r;
  assign mem_rd_addr = idx_r[IW-1:0];
  assign mem_wr_en   = (state_r == ST_DECIDE) && res_free && keep;
  assign mem_wr_addr = count_r[IW-1:0];
  assign mem_wr_data = word_r;

  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    res_valid_nxt = res_valid_r;
    res_nxt       = res_r;

    if (res_valid_r && res_ready) begin
      res_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          word_nxt  = in_value;
          last_nxt  = in_last;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pend_nxt = issue;
        if (issue) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (hit) begin
          found_nxt = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = ST_DECIDE;
        end else if (!issue) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (res_free) begin
          res_nxt.value_out    = word_r;
          res_nxt.keep         = keep;
          res_nxt.unique_count = count_ext[UCNT_W-1:0];
          res_nxt.overflow     = ovf;
          res_nxt.last_out     = last_r;
          res_valid_nxt        = 1'b1;
          count_nxt            = last_r ? '0 : new_count;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      res_valid_r <= res_valid_nxt;
    end
    word_r  <= word_nxt;
    last_r  <= last_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    res_r   <= res_nxt;
  end

endmodule

// ===== rtl/fodf_chk.sv =====
// port-level assertions for the dedup filter and their binding
module fodf_chk #(
  parameter int STORE_DEPTH = 256
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import fodf_pkg::*;

  localparam logic [UCNT_W-1:0] FULL_UCNT = UCNT_W'(STORE_DEPTH);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready in the cycle after an accepted beat");

  a_keep_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("keep and overflow both set");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[40:32] == FULL_UCNT)
    else $error("overflow reported with store not full");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind first_occurrence_dedup_filter_top fodf_chk #(.STORE_DEPTH(STORE_DEPTH)) u_fodf_chk (.*);

// ===== verif/first_occurrence_dedup_filter_top_tb.sv =====
// testbench for the first-occurrence dedup filter: random sets checked against a keep-first predictor
`timescale 1ns / 100ps

module first_occurrence_dedup_filter_top_tb;
  import fodf_pkg::*;

  localparam int DEPTH       = 256;
  localparam int WORD_TARGET = 1250;
  localparam int CYCLE_LIMIT = 1500000;

  class dedup_scoreboard;
    logic [WORD_W-1:0] kept_words [DEPTH];
    int unsigned       kept_n;
    bit                ovf_seen;
    res_beat_t         pending [$];
    int                errors;
    int                checked;
    int                overflow_drops;
    int unsigned       peak_count;

    function void note_input(logic [WORD_W-1:0] word, logic is_last);
      res_beat_t r;
      bit        hit;
      int        k;
      hit = 1'b0;
      for (k = 0; k < kept_n; k++) begin
        if (kept_words[k] == word) hit = 1'b1;
      end
      r.value_out = word;
      r.keep      = 1'b0;
      r.overflow  = 1'b0;
      r.last_out  = is_last;
      if (!hit) begin
        if (kept_n < DEPTH) begin
          kept_words[kept_n] = word;
          kept_n++;
          r.keep = 1'b1;
        end else begin
          r.overflow = 1'b1;
          ovf_seen   = 1'b1;
          overflow_drops++;
        end
      end
      r.unique_count = UCNT_W'(kept_n);
      if (kept_n > peak_count) peak_count = kept_n;
      pending.push_back(r);
      if (is_last) begin
        kept_n   = 0;
        ovf_seen = 1'b0;
      end
    endfunction

    function void check_result(logic [47:0] tdata, logic [1:0] tuser, logic tlast);
      res_beat_t want;
      if (pending.size() == 0) begin
        $error("result beat with no expectation: value_out %h", tdata[31:0]);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (tdata[31:0] !== want.value_out) begin
        $error("value_out mismatch: expected %h, actual %h", want.value_out, tdata[31:0]);
        errors++;
      end
      if (tdata[40:32] !== want.unique_count) begin
        $error("unique_count mismatch: expected %0d, actual %0d", want.unique_count,
               tdata[40:32]);
        errors++;
      end
      if (tuser[0] !== want.keep) begin
        $error("keep mismatch: expected %0d, actual %0d", want.keep, tuser[0]);
        errors++;
      end
      if (tuser[1] !== want.overflow) begin
        $error("overflow mismatch: expected %0d, actual %0d", want.overflow, tuser[1]);
        errors++;
      end
      if (tlast !== want.last_out) begin
        $error("last_out mismatch: expected %0d, actual %0d", want.last_out, tlast);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  dedup_scoreboard sb = new();
  int          send_idle_pct  = 0;
  int          stall_pct      = 0;
  int          words_sent     = 0;
  int          sets_sent      = 0;
  int unsigned cycles         = 0;
  logic [31:0] extremes [4]   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

  first_occurrence_dedup_filter_top #(.STORE_DEPTH(DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic apply_phase(input int p);
    case (p % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 66; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 66; end
      default: begin send_idle_pct = 26; stall_pct = 26; end
    endcase
  endtask

  task automatic send_word(input logic [31:0] word, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    sb.note_input(word, is_last);
    words_sent++;
    if (is_last) sets_sent++;
  endtask

  // short set drawn from a small pool so that repeats are common
  task automatic run_short_set();
    logic [31:0] pool [8];
    logic [31:0] w;
    int          len;
    int          pool_sz;
    int          i;
    len     = $urandom_range(24, 1);
    pool_sz = $urandom_range(8, 1);
    for (i = 0; i < pool_sz; i++) begin
      pool[i] = ($urandom_range(9) == 0) ? extremes[$urandom_range(3)] : $urandom;
    end
    for (i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0:       w = $urandom;
        1:       w = extremes[$urandom_range(3)];
        default: w = pool[$urandom_range(pool_sz - 1)];
      endcase
      send_word(w, i == len - 1);
    end
  endtask

  // fills the store, then mixes new words, dropped words and stored repeats
  task automatic run_long_set();
    logic [31:0] filled [DEPTH];
    logic [31:0] dropped [$];
    logic [31:0] w;
    int          tail;
    int          i;
    tail = $urandom_range(40, 20);
    for (i = 0; i < DEPTH; i++) begin
      filled[i] = $urandom;
      send_word(filled[i], 1'b0);
    end
    for (i = 0; i < tail; i++) begin
      case ($urandom_range(2))
        0: begin
          w = $urandom;
          dropped.push_back(w);
        end
        1:       w = (dropped.size() > 0) ? dropped[$urandom_range(dropped.size() - 1)]
                                          : $urandom;
        default: w = filled[$urandom_range(DEPTH - 1)];
      endcase
      send_word(w, i == tail - 1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    apply_phase(0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h0000_0001, 1'b1);
    // store cleared: same words are new again
    send_word(32'h0000_0000, 1'b1);
    send_word(32'h5A5A_A5A5, 1'b0);
    send_word(32'hA5A5_5A5A, 1'b0);
    send_word(32'h5A5A_A5A5, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);

    while (words_sent < WORD_TARGET) begin
      apply_phase(sets_sent / 7);
      if (sets_sent == 12 || sets_sent == 45) run_long_set();
      else run_short_set();
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    $display("%0d words in %0d sets, %0d results checked", words_sent, sets_sent, sb.checked);
    $display("%0d overflow drops, peak unique count %0d", sb.overflow_drops, sb.peak_count);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fodf_pkg.sv
rtl/fodf_store.sv
rtl/fodf_ctrl.sv
rtl/first_occurrence_dedup_filter_top.sv
rtl/fodf_chk.sv
verif/first_occurrence_dedup_filter_top_tb.sv
